/* rtl/matrix_orientation_transform_assert.svh */
// assertion macros for the orientation transform block
// expects signals named clk and rst in the including module
`ifndef MATRIX_ORIENTATION_TRANSFORM_ASSERT_SVH
`define MATRIX_ORIENTATION_TRANSFORM_ASSERT_SVH

// same-cycle implication, inactive during reset
`define MOT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("orientation transform check failed");

// next-cycle implication, inactive during reset
`define MOT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("orientation transform check failed");

`endif

/* rtl/mto_pkg.sv */
// shared types, codes and the orientation update function
// for the orientation transform block; no dependencies
package mto_pkg;

  localparam int DIM_W = 9;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_LETTER = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [7:0] LTR_TRANSPOSE  = 8'h31;
  localparam logic [7:0] LTR_ANTI_TRANS = 8'h32;
  localparam logic [7:0] LTR_FLIP_V     = 8'h48;
  localparam logic [7:0] LTR_FLIP_H     = 8'h56;
  localparam logic [7:0] LTR_CW_A       = 8'h41;
  localparam logic [7:0] LTR_CW_Z       = 8'h5A;
  localparam logic [7:0] LTR_R180_B     = 8'h42;
  localparam logic [7:0] LTR_R180_Y     = 8'h59;
  localparam logic [7:0] LTR_CCW_C      = 8'h43;
  localparam logic [7:0] LTR_CCW_X      = 8'h58;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
  } req_t;

  typedef struct packed {
    logic [7:0]       cell_value;
    logic [DIM_W-1:0] out_rows;
    logic [DIM_W-1:0] out_cols;
    logic             last_cell;
  } rsp_t;

  // transpose first, then reverse rows, then reverse columns
  typedef struct packed {
    logic swap;
    logic fv;
    logic fh;
  } orient_t;

  typedef struct packed {
    logic             valid;
    logic [DIM_W-1:0] out_rows;
    logic [DIM_W-1:0] out_cols;
    logic             last_cell;
  } rd_meta_t;

  function automatic orient_t transpose_then(orient_t o, logic fv, logic fh);
    orient_t r;
    r.fv   = o.fh ^ fv;
    r.fh   = o.fv ^ fh;
    r.swap = ~o.swap;
    return r;
  endfunction

  function automatic orient_t apply_letter(orient_t o, logic [7:0] ch);
    orient_t r;
    r = o;
    case (ch)
      LTR_TRANSPOSE:  r = transpose_then(o, 1'b0, 1'b0);
      LTR_ANTI_TRANS: r = transpose_then(o, 1'b1, 1'b1);
      LTR_FLIP_V:     r.fv = ~o.fv;
      LTR_FLIP_H:     r.fh = ~o.fh;
      LTR_CW_A,
      LTR_CW_Z:       r = transpose_then(o, 1'b0, 1'b1);
      LTR_R180_B,
      LTR_R180_Y: begin
        r.fv = ~o.fv;
        r.fh = ~o.fh;
      end
      LTR_CCW_C,
      LTR_CCW_X:      r = transpose_then(o, 1'b1, 1'b0);
      default:        r = o;
    endcase
    return r;
  endfunction

endpackage

/* rtl/mto_frame_mem.sv */
// frame store: one write port, one read port with registered data
// no dependencies
module mto_frame_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/mto_ctrl.sv */
// frame geometry, orientation, load pointer and read position;
// computes the source address of each read; uses mto_pkg
module mto_ctrl #(
  parameter int MAX_DIM = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [mto_pkg::DIM_W-1:0]      cfg_data,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  mto_pkg::req_t                  req,
  input  logic                           advance,
  output logic                           wr_en,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] wr_addr,
  output logic [7:0]                     wr_data,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] rd_addr,
  output mto_pkg::rd_meta_t              rd_meta
);

  localparam int DW  = $clog2(MAX_DIM + 1);
  localparam int DW2 = 2 * DW;
  localparam int PW  = $clog2(MAX_DIM);
  localparam int AW  = $clog2(MAX_DIM * MAX_DIM);
  localparam int LW  = AW + 1;

  logic [DW-1:0]     rows, cols;
  mto_pkg::orient_t  orient;
  logic [LW-1:0]     load_ptr;
  logic [PW-1:0]     read_row, read_col;

  logic              accept;
  logic [DW-1:0]     cfg_dim;
  logic [DW2-1:0]    frame_cells;
  logic              load_ok;
  logic [DW-1:0]     orows, ocols;
  logic              pos_oob;
  logic [PW-1:0]     rr, rc;
  logic [DW-1:0]     r2, c2;
  logic [DW-1:0]     mul_a, mul_b;
  logic [DW2-1:0]    product;
  logic              row_end, is_last;

  assign req_ready = !rd_meta.valid || advance;
  assign accept    = req_valid && req_ready;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_dim = DW'(1);
    end else if (int'(cfg_data) > MAX_DIM) begin
      cfg_dim = DW'(MAX_DIM);
    end else begin
      cfg_dim = DW'(cfg_data);
    end
  end

  // load side
  assign frame_cells = DW2'(rows) * DW2'(cols);
  assign load_ok     = DW2'(load_ptr) < frame_cells;
  assign wr_en       = accept && (req.cmd == mto_pkg::CMD_LOAD) && load_ok;
  assign wr_addr     = load_ptr[AW-1:0];
  assign wr_data     = req.data;

  // read side
  always_comb begin
    orows   = orient.swap ? cols : rows;
    ocols   = orient.swap ? rows : cols;
    pos_oob = (DW'(read_row) >= orows) || (DW'(read_col) >= ocols);
    rr      = pos_oob ? '0 : read_row;
    rc      = pos_oob ? '0 : read_col;
    r2      = orient.fv ? (orows - DW'(rr) - DW'(1)) : DW'(rr);
    c2      = orient.fh ? (ocols - DW'(rc) - DW'(1)) : DW'(rc);
    mul_a   = orient.swap ? c2 : r2;
    mul_b   = orient.swap ? r2 : c2;
    product = DW2'(mul_a) * DW2'(cols);
    row_end = DW'(rc) == (ocols - DW'(1));
    is_last = row_end && (DW'(rr) == (orows - DW'(1)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows          <= DW'(1);
      cols          <= DW'(1);
      orient        <= '0;
      load_ptr      <= '0;
      read_row      <= '0;
      read_col      <= '0;
      rd_meta.valid <= 1'b0;
    end else begin
      if (accept) begin
        case (req.cmd)
          mto_pkg::CMD_LOAD: begin
            if (load_ok) begin
              load_ptr <= load_ptr + LW'(1);
            end
          end
          mto_pkg::CMD_LETTER: begin
            orient <= mto_pkg::apply_letter(orient, req.data);
          end
          mto_pkg::CMD_READ: begin
            if (is_last) begin
              read_row <= '0;
              read_col <= '0;
            end else if (row_end) begin
              read_row <= rr + PW'(1);
              read_col <= '0;
            end else begin
              read_row <= rr;
              read_col <= rc + PW'(1);
            end
          end
          default: begin
          end
        endcase
      end
      if (accept && (req.cmd == mto_pkg::CMD_READ)) begin
        rd_meta.valid     <= 1'b1;
        rd_meta.out_rows  <= mto_pkg::DIM_W'(orows);
        rd_meta.out_cols  <= mto_pkg::DIM_W'(ocols);
        rd_meta.last_cell <= is_last;
      end else if (advance) begin
        rd_meta.valid <= 1'b0;
      end
      // new frame on any register write
      if (cfg_we) begin
        case (cfg_index)
          mto_pkg::REG_ROWS: rows <= cfg_dim;
          mto_pkg::REG_COLS: cols <= cfg_dim;
          default: begin
          end
        endcase
        orient   <= '0;
        load_ptr <= '0;
        read_row <= '0;
        read_col <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (req.cmd == mto_pkg::CMD_READ)) begin
      rd_addr <= AW'(product + DW2'(mul_b));
    end
  end

endmodule

/* rtl/matrix_orientation_transform.sv */
// matrix orientation transform, top level: frame store plus read/write control
// a read transfer registers its address and metadata, then its cell with the
// output stage; load and letter transfers give no result. one transfer per
// cycle sustained unless the output stalls, set by the frame store's single
// write port and single read port. reset (synchronous) sets rows and cols to
// 1, identity orientation, pointers to zero; the frame store is not cleared
`include "matrix_orientation_transform_assert.svh"

module matrix_orientation_transform #(
  parameter int MAX_DIM = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [mto_pkg::DIM_W-1:0] cfg_data,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  mto_pkg::req_t             req,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output mto_pkg::rsp_t             rsp
);

  localparam int AW = $clog2(MAX_DIM * MAX_DIM);

  mto_pkg::rd_meta_t rd_meta;
  logic              advance;
  logic              rd_en;
  logic              wr_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [7:0]        wr_data, rd_data;
  logic [mto_pkg::DIM_W-1:0] out_rows, out_cols;
  logic              last_cell;
  logic              read_xfer;

  assign advance   = !rsp_valid || rsp_ready;
  assign rd_en     = rd_meta.valid && advance;
  assign read_xfer = req_valid && req_ready && (req.cmd == mto_pkg::CMD_READ);

  mto_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .advance   (advance),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_meta   (rd_meta)
  );

  mto_frame_mem #(
    .DEPTH (MAX_DIM * MAX_DIM),
    .AW    (AW)
  ) u_frame_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output stage, filled together with the memory read register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= rd_meta.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      out_rows  <= rd_meta.out_rows;
      out_cols  <= rd_meta.out_cols;
      last_cell <= rd_meta.last_cell;
    end
  end

  always_comb begin
    rsp.cell_value = rd_data;
    rsp.out_rows   = out_rows;
    rsp.out_cols   = out_cols;
    rsp.last_cell  = last_cell;
  end

  `MOT_ASSERT_NEXT(a_read_enters_stage, read_xfer, rd_meta.valid)
  `MOT_ASSERT_NEXT(a_stage_holds_on_stall, rd_meta.valid && !advance, rd_meta.valid)
  `MOT_ASSERT_NOW(a_dims_nonzero, rsp_valid, (rsp.out_rows != '0) && (rsp.out_cols != '0))

endmodule
